/* hdl/dpc_pkg.sv */
// Shared types and constants for the dew point calculator.
// Holds the request and result structs used by the top level and its checker.
// No dependencies.
package dpc_pkg;

  // Default fraction width of the internal fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Range limits of the dew point result, hundredths of a degree C
  localparam int DP_MIN = -10000;
  localparam int DP_MAX = 12500;

  // Full-scale humidity, hundredths of a percent
  localparam int HUM_FULL = 10000;

  typedef struct packed {
    logic signed [14:0] temperature;
    logic        [13:0] humidity;
  } dpc_in_t;

  typedef struct packed {
    logic signed [14:0] dew_point;
    logic               valid_res;
  } dpc_out_t;

endpackage

/* hdl/dpc_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a valid bit and a sideband word alongside each division.
// Depends on no package.
module dpc_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int ACC_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [ACC_W-1:0]  rem_r  [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];
  logic              vld_r  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int B = QUO_W - 1 - j;
    logic [ACC_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [ACC_W-1:0]  dsh;
    logic              take;
    logic [ACC_W-1:0]  rem_nxt;
    logic [QUO_W-1:0]  quo_nxt;

    // Select the stage input: request port or previous stage
    if (j == 0) begin : g_first
      assign rem_in  = ACC_W'(in_num);
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    // Trial subtract of the shifted divisor decides one quotient bit
    assign dsh     = ACC_W'(den_in) << B;
    assign take    = (rem_in >= dsh);
    assign rem_nxt = take ? (rem_in - dsh) : rem_in;
    assign quo_nxt = quo_in | (QUO_W'(take) << B);

    // Advance the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j]  <= vld_in;
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        quo_r[j]  <= quo_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = quo_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule

/* hdl/dew_point_calculator.sv */
// Dew point by the Magnus formula in fixed point, fully pipelined.
// Depends on dpc_pkg and dpc_div.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------
//   in_     | request   | in_valid / in_ready | dpc_in_t  (temperature, humidity)
//   out_    | result    | out_valid/out_ready | dpc_out_t (dew_point, valid_res)
//
// One request enters per cycle while no stalled result holds the pipeline. It
// runs through three bit-per-stage dividers: the temperature term, the atanh
// argument and the final quotient. The mantissa is a two-stage reciprocal
// multiply.
// Reset clears all valid bits; payload registers are left as they are.
// A stalled result freezes the whole pipeline; the input register still takes
// a request while it is empty, so nothing is dropped or repeated.
module dew_point_calculator #(
  parameter int FRAC_BITS = dpc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpc_pkg::dpc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dpc_pkg::dpc_out_t out_data
);

  import dpc_pkg::*;

  localparam int F = FRAC_BITS;

  // Rounded fixed-point constants
  localparam longint ONE   = longint'(1) << F;
  localparam longint HALF  = ONE >> 1;
  localparam longint A_Q   = (1762 * ONE + 50) / 100;
  localparam longint LN2_Q = (longint'(69314718) * ONE + 50000000) / 100000000;
  localparam longint C3    = (ONE + 1) / 3;
  localparam longint C5    = (ONE + 2) / 5;
  localparam longint C7    = (ONE + 3) / 7;

  // Mantissa by reciprocal: ONE = MANT_A*10000 + MANT_B
  localparam longint MANT_A   = ONE / HUM_FULL;
  localparam longint MANT_B   = ONE % HUM_FULL;
  localparam longint MANT_RCP = 219902326;   // ceil(2^41 / 10000)
  localparam int     MANT_SH  = 41;

  // Widths
  localparam int K_W    = 4;
  localparam int HN_W   = 15;
  localparam int G_W    = F + 7;
  localparam int DR_NW  = F + 26;
  localparam int DR_DW  = 22;
  localparam int DR_QW  = F + 6;
  localparam int MR_W   = 14;
  localparam int MY_W   = 28;
  localparam int MP_W   = 2 * MY_W;
  localparam int M_W    = F + 2;
  localparam int D2_NW  = 2 * F + 1;
  localparam int D2_DW  = F + 2;
  localparam int T_W    = F;
  localparam int P_W    = 2 * F;
  localparam int KL_W   = F + 4;
  localparam int DEN_W  = F + 6;
  localparam int D4_NW  = F + 22;
  localparam int D4_QW  = 16;
  localparam int S1_W   = 2 + K_W + HN_W;
  localparam int S2_W   = 1 + K_W + G_W;
  localparam int S4_W   = 3;

  logic en;

  // ---------------- input register ----------------
  logic    s0_vld_r;
  dpc_in_t s0_data_r;

  assign en       = !out_valid | out_ready;
  assign in_ready = en | !s0_vld_r;

  // Take a request whenever the register is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ready) begin
      s0_vld_r  <= in_valid;
      s0_data_r <= in_data;
    end
  end

  // ---------------- prepare temperature term and normalize humidity ----------------
  logic               p1_vres;
  logic [K_W-1:0]     p1_k;
  logic [HN_W-1:0]    p1_hn;
  logic               p1_tneg;
  logic [14:0]        p1_tmag;
  logic signed [16:0] p1_tsum;
  logic [DR_DW-1:0]   p1_den;
  logic [DR_NW-1:0]   p1_num;
  logic [27:0]        p1_hsh;

  always_comb begin
    p1_vres = (s0_data_r.humidity != '0) && (32'(s0_data_r.humidity) <= HUM_FULL);
    // smallest shift that brings humidity up to full scale, capped at 14
    p1_k = K_W'(14);
    for (int i = 14; i >= 0; i--) begin
      if ((28'(s0_data_r.humidity) << i) >= 28'(HUM_FULL)) begin
        p1_k = K_W'(i);
      end
    end
    p1_hsh  = 28'(s0_data_r.humidity) << p1_k;
    p1_hn   = p1_hsh[HN_W-1:0];
    p1_tneg = s0_data_r.temperature[14];
    p1_tmag = p1_tneg ? 15'(-s0_data_r.temperature) : 15'(s0_data_r.temperature);
    p1_tsum = 17'(s0_data_r.temperature) + 17'sd24312;
    p1_den  = DR_DW'(p1_tsum[15:0]) * DR_DW'(100);
    p1_num  = ((DR_NW'(p1_tmag) * DR_NW'(1762)) << F) + DR_NW'(p1_den >> 1);
  end

  logic             p1_vld_r;
  logic [DR_NW-1:0] p1_num_r;
  logic [DR_DW-1:0] p1_den_r;
  logic [S1_W-1:0]  p1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r  <= s0_vld_r;
      p1_num_r  <= p1_num;
      p1_den_r  <= p1_den;
      p1_side_r <= {p1_vres, p1_tneg, p1_k, p1_hn};
    end
  end

  // ---------------- temperature term a*T/(b+T) ----------------
  logic             dr_vld;
  logic [DR_QW-1:0] dr_quo;
  logic [S1_W-1:0]  dr_side;

  dpc_div #(
    .NUM_W(DR_NW), .DEN_W(DR_DW), .QUO_W(DR_QW), .SIDE_W(S1_W)
  ) u_div_temp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(p1_vld_r), .in_num(p1_num_r), .in_den(p1_den_r), .in_side(p1_side_r),
    .out_vld(dr_vld), .out_quo(dr_quo), .out_side(dr_side)
  );

  // ---------------- apply sign, split humidity for the mantissa ----------------
  logic                  p2_vres;
  logic                  p2_tneg;
  logic [K_W-1:0]        p2_k;
  logic [HN_W-1:0]       p2_hn;
  logic signed [G_W-1:0] p2_r;
  logic [HN_W-1:0]       p2_hd;
  logic [MR_W-1:0]       p2_rem;
  logic [M_W-1:0]        p2_ra;
  logic [MY_W-1:0]       p2_y;

  assign {p2_vres, p2_tneg, p2_k, p2_hn} = dr_side;
  assign p2_r   = p2_tneg ? -G_W'(dr_quo) : G_W'(dr_quo);
  // m = ONE + rem*MANT_A + round(rem*MANT_B / 10000), rem = H*2^k - 10000
  assign p2_hd  = p2_hn - HN_W'(HUM_FULL);
  assign p2_rem = p2_hd[MR_W-1:0];
  assign p2_ra  = M_W'(p2_rem) * M_W'(MANT_A);
  assign p2_y   = MY_W'(p2_rem) * MY_W'(MANT_B) + MY_W'(HUM_FULL / 2);

  logic            p2_vld_r;
  logic [M_W-1:0]  p2_ra_r;
  logic [MY_W-1:0] p2_y_r;
  logic [S2_W-1:0] p2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r  <= dr_vld;
      p2_ra_r   <= p2_ra;
      p2_y_r    <= p2_y;
      p2_side_r <= {p2_vres, p2_k, p2_r};
    end
  end

  // ---------------- mantissa m = H*2^k / 10000 ----------------
  logic [MP_W-1:0] md_prod;
  assign md_prod = MP_W'(p2_y_r) * MP_W'(MANT_RCP);

  logic            md_vld_r;
  logic [M_W-1:0]  md_m_r;
  logic [S2_W-1:0] md_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_vld_r <= 1'b0;
    end else if (en) begin
      md_vld_r  <= p2_vld_r;
      md_m_r    <= M_W'(ONE) + p2_ra_r + M_W'(md_prod >> MANT_SH);
      md_side_r <= p2_side_r;
    end
  end

  // ---------------- prepare (m-1)/(m+1) ----------------
  logic [D2_DW-1:0] p3_den;
  logic [D2_NW-1:0] p3_mm1;
  logic [D2_NW-1:0] p3_num;

  assign p3_den = D2_DW'(md_m_r) + D2_DW'(ONE);
  assign p3_mm1 = D2_NW'(md_m_r) - D2_NW'(ONE);
  assign p3_num = (p3_mm1 << F) + D2_NW'(p3_den >> 1);

  logic             p3_vld_r;
  logic [D2_NW-1:0] p3_num_r;
  logic [D2_DW-1:0] p3_den_r;
  logic [S2_W-1:0]  p3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r  <= md_vld_r;
      p3_num_r  <= p3_num;
      p3_den_r  <= p3_den;
      p3_side_r <= md_side_r;
    end
  end

  // ---------------- series argument t ----------------
  logic            d2_vld;
  logic [T_W-1:0]  d2_quo;
  logic [S2_W-1:0] d2_side;

  dpc_div #(
    .NUM_W(D2_NW), .DEN_W(D2_DW), .QUO_W(T_W), .SIDE_W(S2_W)
  ) u_div_atanh (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(p3_vld_r), .in_num(p3_num_r), .in_den(p3_den_r), .in_side(p3_side_r),
    .out_vld(d2_vld), .out_quo(d2_quo), .out_side(d2_side)
  );

  // ---------------- series: t2 = t*t ----------------
  logic [P_W-1:0] m1_prod;
  assign m1_prod = P_W'(d2_quo) * P_W'(d2_quo);

  logic            m1_vld_r;
  logic [T_W-1:0]  m1_t_r;
  logic [T_W-1:0]  m1_t2_r;
  logic [S2_W-1:0] m1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r  <= d2_vld;
      m1_t_r    <= d2_quo;
      m1_t2_r   <= T_W'((m1_prod + P_W'(HALF)) >> F);
      m1_side_r <= d2_side;
    end
  end

  // ---------------- series: p = 1/5 + t2/7 ----------------
  logic [P_W-1:0] m2_prod;
  assign m2_prod = P_W'(m1_t2_r) * P_W'(C7);

  logic            m2_vld_r;
  logic [T_W-1:0]  m2_t_r;
  logic [T_W-1:0]  m2_t2_r;
  logic [T_W-1:0]  m2_p_r;
  logic [S2_W-1:0] m2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r  <= m1_vld_r;
      m2_t_r    <= m1_t_r;
      m2_t2_r   <= m1_t2_r;
      m2_p_r    <= T_W'(C5) + T_W'((m2_prod + P_W'(HALF)) >> F);
      m2_side_r <= m1_side_r;
    end
  end

  // ---------------- series: p = 1/3 + t2*p ----------------
  logic [P_W-1:0] m3_prod;
  assign m3_prod = P_W'(m2_t2_r) * P_W'(m2_p_r);

  logic            m3_vld_r;
  logic [T_W-1:0]  m3_t_r;
  logic [T_W-1:0]  m3_t2_r;
  logic [T_W-1:0]  m3_p_r;
  logic [S2_W-1:0] m3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m3_vld_r  <= m2_vld_r;
      m3_t_r    <= m2_t_r;
      m3_t2_r   <= m2_t2_r;
      m3_p_r    <= T_W'(C3) + T_W'((m3_prod + P_W'(HALF)) >> F);
      m3_side_r <= m2_side_r;
    end
  end

  // ---------------- series: p = 1 + t2*p ----------------
  logic [P_W-1:0] m4_prod;
  assign m4_prod = P_W'(m3_t2_r) * P_W'(m3_p_r);

  logic            m4_vld_r;
  logic [T_W-1:0]  m4_t_r;
  logic [T_W:0]    m4_p_r;
  logic [S2_W-1:0] m4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_vld_r <= 1'b0;
    end else if (en) begin
      m4_vld_r  <= m3_vld_r;
      m4_t_r    <= m3_t_r;
      m4_p_r    <= (T_W+1)'(ONE) + (T_W+1)'((m4_prod + P_W'(HALF)) >> F);
      m4_side_r <= m3_side_r;
    end
  end

  // ---------------- series: u = t*p, and k*ln2 ----------------
  logic                  m5_vres;
  logic [K_W-1:0]        m5_k;
  logic signed [G_W-1:0] m5_r;
  logic [P_W:0]          m5_prod;

  assign {m5_vres, m5_k, m5_r} = m4_side_r;
  assign m5_prod = (P_W+1)'(m4_t_r) * (P_W+1)'(m4_p_r);

  logic                  m5_vld_r;
  logic [T_W-1:0]        m5_u_r;
  logic [KL_W-1:0]       m5_kln2_r;
  logic signed [G_W-1:0] m5_r_r;
  logic                  m5_vres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m5_vld_r <= 1'b0;
    end else if (en) begin
      m5_vld_r  <= m4_vld_r;
      m5_u_r    <= T_W'((m5_prod + (P_W+1)'(HALF)) >> F);
      m5_kln2_r <= KL_W'(m5_k) * KL_W'(LN2_Q);
      m5_r_r    <= m5_r;
      m5_vres_r <= m5_vres;
    end
  end

  // ---------------- g = ln x + r, denominator a - g ----------------
  logic signed [G_W:0] g1_g;
  logic signed [G_W:0] g1_den;

  assign g1_g   = (G_W+1)'({m5_u_r, 1'b0}) - (G_W+1)'(m5_kln2_r) + (G_W+1)'(m5_r_r);
  assign g1_den = (G_W+1)'(A_Q) - g1_g;

  logic                  g1_vld_r;
  logic signed [G_W-1:0] g1_g_r;
  logic signed [G_W:0]   g1_den_r;
  logic                  g1_vres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
    end else if (en) begin
      g1_vld_r  <= m5_vld_r;
      g1_g_r    <= g1_g[G_W-1:0];
      g1_den_r  <= g1_den;
      g1_vres_r <= m5_vres_r;
    end
  end

  // ---------------- numerator |b*g| + den/2 ----------------
  logic                  g2_gneg;
  logic [G_W-2:0]        g2_gmag;
  logic signed [G_W-1:0] g2_gabs;
  logic                  g2_dpos;
  logic [DEN_W-1:0]      g2_den;
  logic [D4_NW-1:0]      g2_num;

  assign g2_gneg = g1_g_r[G_W-1];
  assign g2_gabs = g2_gneg ? -g1_g_r : g1_g_r;
  assign g2_gmag = g2_gabs[G_W-2:0];
  assign g2_dpos = !g1_den_r[G_W] && (g1_den_r != '0);
  assign g2_den  = g1_den_r[DEN_W-1:0];
  assign g2_num  = D4_NW'(g2_gmag) * D4_NW'(24312) + D4_NW'(g2_den >> 1);

  logic             g2_vld_r;
  logic [D4_NW-1:0] g2_num_r;
  logic [DEN_W-1:0] g2_den_r;
  logic [S4_W-1:0]  g2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_vld_r <= 1'b0;
    end else if (en) begin
      g2_vld_r  <= g1_vld_r;
      g2_num_r  <= g2_num;
      g2_den_r  <= g2_den;
      g2_side_r <= {g1_vres_r, g2_gneg, g2_dpos};
    end
  end

  // ---------------- dew point quotient ----------------
  logic             d4_vld;
  logic [D4_QW-1:0] d4_quo;
  logic [S4_W-1:0]  d4_side;

  dpc_div #(
    .NUM_W(D4_NW), .DEN_W(DEN_W), .QUO_W(D4_QW), .SIDE_W(S4_W)
  ) u_div_dew (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(g2_vld_r), .in_num(g2_num_r), .in_den(g2_den_r), .in_side(g2_side_r),
    .out_vld(d4_vld), .out_quo(d4_quo), .out_side(d4_side)
  );

  // ---------------- sign, saturate, drop invalid humidity ----------------
  logic               o_vres;
  logic               o_gneg;
  logic               o_dpos;
  logic signed [16:0] o_td;
  logic signed [14:0] o_dew;

  assign {o_vres, o_gneg, o_dpos} = d4_side;

  always_comb begin
    o_td = o_gneg ? -17'(d4_quo) : 17'(d4_quo);
    if (!o_vres) begin
      o_dew = '0;
    end else if (!o_dpos) begin
      o_dew = 15'(DP_MAX);
    end else if (o_td < 17'(DP_MIN)) begin
      o_dew = 15'(DP_MIN);
    end else if (o_td > 17'(DP_MAX)) begin
      o_dew = 15'(DP_MAX);
    end else begin
      o_dew = o_td[14:0];
    end
  end

  logic     out_valid_r;
  dpc_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r          <= d4_vld;
      out_data_r.dew_point <= o_dew;
      out_data_r.valid_res <= o_vres;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/dpc_checker.sv */
// Port-level checks for the dew point calculator, with a bind to the top level.
// Depends on dpc_pkg and dew_point_calculator.
module dpc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dpc_pkg::dpc_out_t out_data
);

  import dpc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // Rejected humidity gives a zero dew point
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.dew_point == 15'sd0)
    else $error("invalid result carries a nonzero dew point");

  // Saturate into the documented range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dew_point >= 15'(DP_MIN)) && (out_data.dew_point <= 15'(DP_MAX)))
    else $error("dew point outside saturation range");

  // Drop all results in reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Accept a request whenever the result side moves on
  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("request refused while results advance");

endmodule

bind dew_point_calculator dpc_checker u_dpc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
